// File: sv/timed_reading_interpolator_macros.svh
// Assertion macros shared by the checker of the interpolator.
// Depends on nothing; included by files that assert.
`ifndef TIMED_READING_INTERPOLATOR_MACROS_SVH
`define TIMED_READING_INTERPOLATOR_MACROS_SVH
// implication checked on every clock, off during reset
`define TRI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, off during reset
`define TRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/tri_pkg.sv
// Package of the timed reading interpolator: payload types, codes, constants.
// Depends on nothing; used by every module of the block.
package tri_pkg;
   localparam int TableDepth = 64;

   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_RSVD  = 2'd3
   } status_code_type;

   localparam logic signed [15:0] TempEmpty = -16'sd256;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        stamp;
      logic signed [15:0] reading;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] temp_out;
      logic [1:0]         status;
   } rsp_word_type;
endpackage

// File: sv/tri_front.sv
// Front end of the interpolator: two-entry request queue between ports and engine.
// Depends on tri_pkg.
module tri_front
   import tri_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   output logic         deq_valid,
   input  logic         deq_take,
   output req_word_type deq_word
);
   req_word_type slot_ff [2];
   req_word_type slot_in [2];
   logic         rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push_ok, take_ok;

   assign req_full  = (cnt_ff == 2'd2);
   assign deq_valid = (cnt_ff != 2'd0);
   assign deq_word  = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = deq_take && deq_valid;

   always_comb begin
      slot_in   = slot_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         slot_in[wr_ptr_ff] = req_word;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (take_ok) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, take_ok};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

// File: sv/tri_engine.sv
// Back end of the interpolator: table memory, scan sequencer, serial divider,
// result register. Depends on tri_pkg.
module tri_engine
   import tri_pkg::*;
#(
   parameter int Depth = TableDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         deq_valid,
   output logic         deq_take,
   input  req_word_type deq_word,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);
   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_RD0   = 8'b00000010,
      ST_SCAN  = 8'b00000100,
      ST_RDLO  = 8'b00001000,
      ST_RDHI  = 8'b00010000,
      ST_MUL   = 8'b00100000,
      ST_DIV   = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   logic [31:0]        mem_time [Depth];
   logic signed [15:0] mem_temp [Depth];
   logic [31:0]        rd_time_ff;
   logic signed [15:0] rd_temp_ff;
   logic [IdxW-1:0]    rd_addr;

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    idx_ff, idx_in;
   logic [IdxW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic               have_hi_ff, have_hi_in;
   logic               pend_ff, pend_in;  // scan read in flight
   logic [IdxW-1:0]    pidx_ff, pidx_in;
   logic [31:0]        qt_ff, qt_in;
   logic [31:0]        tlo_ff, tlo_in;
   logic signed [15:0] vlo_ff, vlo_in;
   logic [31:0]        span_ff, span_in;
   logic signed [16:0] dtemp_ff, dtemp_in;
   logic [48:0]        num_ff, num_in;    // |dtemp * dt|
   logic               neg_ff, neg_in;
   logic [32:0]        rem_ff, rem_in;
   logic [5:0]         bit_ff, bit_in;
   logic               rsp_full_ff, rsp_full_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic               wr_en;
   logic [32:0]        rem_sh;
   logic [48:0]        q_tmp;
   logic [16:0]        dtemp_abs;
   logic signed [17:0] sum_tmp;

   assign rsp_empty = !rsp_full_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_time[count_ff[IdxW-1:0]] <= deq_word.stamp;
         mem_temp[count_ff[IdxW-1:0]] <= deq_word.reading;
      end
      rd_time_ff <= mem_time[rd_addr];
      rd_temp_ff <= mem_temp[rd_addr];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      have_hi_in  = have_hi_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      qt_in       = qt_ff;
      tlo_in      = tlo_ff;
      vlo_in      = vlo_ff;
      span_in     = span_ff;
      dtemp_in    = dtemp_ff;
      num_in      = num_ff;
      neg_in      = neg_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      rsp_full_in = rsp_full_ff && !rsp_pop;
      rsp_in      = rsp_ff;
      deq_take    = 1'b0;
      wr_en       = 1'b0;
      rd_addr     = '0;
      rem_sh      = '0;
      q_tmp       = '0;
      dtemp_abs   = '0;
      sum_tmp     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (deq_valid && !rsp_full_in) begin
               deq_take = 1'b1;
               rsp_in   = '{temp_out: 16'sd0, status: STS_OK};
               unique case (deq_word.req_type)
                  REQ_APPEND: begin
                     if (count_ff < CntW'(Depth)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_in.status = STS_FULL;
                     end
                     rsp_full_in = 1'b1;
                  end
                  REQ_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_in      = '{temp_out: TempEmpty, status: STS_EMPTY};
                        rsp_full_in = 1'b1;
                     end else begin
                        qt_in      = deq_word.stamp;
                        idx_in     = '0;
                        lo_in      = '0;
                        have_hi_in = 1'b0;
                        state_in   = ST_RD0;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in    = '0;
                     rsp_full_in = 1'b1;
                  end
                  REQ_NONE: rsp_full_in = 1'b1;
                  default:  rsp_full_in = 1'b1;
               endcase
            end
         end
         ST_RD0: begin
            // rd_addr zero: entry 0 arrives next cycle
            pend_in  = 1'b1;
            pidx_in  = '0;
            idx_in   = CntW'(1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr = idx_ff[IdxW-1:0];
            if (pend_ff && pidx_ff == '0 && qt_ff < rd_time_ff) begin
               rsp_in      = '{temp_out: rd_temp_ff, status: STS_OK};
               rsp_full_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               if (pend_ff) begin
                  if (rd_time_ff < qt_ff) begin
                     lo_in = pidx_ff;
                  end else if (!have_hi_ff && pidx_ff != '0) begin
                     hi_in      = pidx_ff;
                     have_hi_in = 1'b1;
                  end
               end
               if (idx_ff < count_ff) begin
                  pend_in = 1'b1;
                  pidx_in = idx_ff[IdxW-1:0];
                  idx_in  = idx_ff + 1'b1;
               end else if (!pend_ff) begin
                  state_in = ST_RDLO;
               end
            end
         end
         ST_RDLO: begin
            rd_addr  = lo_ff;
            state_in = ST_RDHI;
         end
         ST_RDHI: begin
            rd_addr = hi_ff;
            tlo_in  = rd_time_ff;
            vlo_in  = rd_temp_ff;
            if (!have_hi_ff) begin
               rsp_in      = '{temp_out: rd_temp_ff, status: STS_OK};
               rsp_full_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (rd_time_ff <= tlo_ff) begin
               rsp_in      = '{temp_out: vlo_ff, status: STS_OK};
               rsp_full_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               span_in   = rd_time_ff - tlo_ff;
               dtemp_in  = 17'(rd_temp_ff) - 17'(vlo_ff);
               neg_in    = dtemp_in[16];
               dtemp_abs = neg_in ? 17'(-dtemp_in) : dtemp_in;
               num_in    = 49'(dtemp_abs) * 49'(qt_ff - tlo_ff);
               rem_in    = '0;
               bit_in    = 6'd48;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle, quotient shifts into num
            rem_sh = {rem_ff[31:0], num_ff[48]};
            num_in = {num_ff[47:0], 1'b0};
            if (rem_sh >= {1'b0, span_ff}) begin
               rem_in    = rem_sh - {1'b0, span_ff};
               num_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               q_tmp       = num_in;
               sum_tmp     = neg_ff ? 18'(vlo_ff) - 18'(q_tmp[16:0])
                                    : 18'(vlo_ff) + 18'(q_tmp[16:0]);
               rsp_in      = '{temp_out: sum_tmp[15:0], status: STS_OK};
               rsp_full_in = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      idx_ff     <= idx_in;
      pidx_ff    <= pidx_in;
      qt_ff      <= qt_in;
      tlo_ff     <= tlo_in;
      vlo_ff     <= vlo_in;
      span_ff    <= span_in;
      dtemp_ff   <= dtemp_in;
      num_ff     <= num_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
      rsp_ff     <= rsp_in;
      have_hi_ff <= have_hi_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pend_ff     <= 1'b0;
         rsp_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_ff     <= pend_in;
         rsp_full_ff <= rsp_full_in;
      end
   end
endmodule

// File: sv/timed_reading_interpolator.sv
// Top level of the timed reading interpolator: request queue plus engine.
// Depends on tri_pkg, tri_front and tri_engine.
// A table of up to Depth timestamped Q8.8 readings. Append and clear are
// answered from the idle state; a query reads entry 0, scans all stored entries one per
// cycle through the single read port of the table memory, reads lo and hi,
// then divides by a restoring divider giving one of 49 quotient bits a cycle.
// A two-word queue in front lets requests arrive while a query runs; one
// result register waits for pop. Table contents are undefined after reset
// and only entries below the count are read.
module timed_reading_interpolator
   import tri_pkg::*;
#(
   parameter int Depth = TableDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);
   logic         deq_valid, deq_take;
   req_word_type deq_word;

   tri_front u_front (
      .clock, .reset, .req_push, .req_full, .req_word,
      .deq_valid, .deq_take, .deq_word
   );

   tri_engine #(.Depth(Depth)) u_engine (
      .clock, .reset, .deq_valid, .deq_take, .deq_word,
      .rsp_empty, .rsp_pop, .rsp_word
   );
endmodule

// File: sv/tri_checker.sv
// Port-level checker of the timed reading interpolator, bound to the top.
// Depends on tri_pkg and the macro header.
`include "timed_reading_interpolator_macros.svh"
module tri_checker
   import tri_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_word_type rsp_word
);
   `TRI_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_word), "result dropped or changed while waiting")
   `TRI_ASSERT_IMP(a_status_code, clock, reset, !rsp_empty, rsp_word.status != STS_RSVD, "reserved status code")
   `TRI_ASSERT_IMP(a_empty_val, clock, reset, !rsp_empty && rsp_word.status == STS_EMPTY, rsp_word.temp_out == TempEmpty, "empty status without -1.0")
   `TRI_ASSERT_IMP(a_full_val, clock, reset, !rsp_empty && rsp_word.status == STS_FULL, rsp_word.temp_out == 16'sd0, "full status with nonzero value")
   `TRI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full, "queues not empty after reset")
endmodule

bind timed_reading_interpolator tri_checker u_checker (.*);
